// ----- hw/rtl/srtc_pkg.sv -----
package srtc_pkg;

  // Field widths.
  localparam int unsigned RATE_W = 16;
  localparam int unsigned VER_W  = 10;
  localparam int unsigned TC_W   = 8;

  // First division: divisor is the clamped rate shifted by the stereo bit.
  localparam int unsigned DIVR_W = RATE_W + 1;
  localparam int unsigned Q_W    = 16;
  // Second division: divisor is q, the quotient is the doubled rate at most.
  localparam int unsigned ACT_W  = RATE_W + 1;

  // The clock numerator, 256000000, needs 28 bits.
  localparam int unsigned NUM_W = 28;
  localparam logic [NUM_W-1:0] CLOCK_NUM = 28'd256000000;

  // Each divider starts from the numerator bits above its quotient width;
  // those bits are smaller than the smallest divisor either one sees.
  localparam logic [DIVR_W-1:0] Q_INIT_REM = DIVR_W'(CLOCK_NUM >> Q_W);
  localparam logic [Q_W-1:0]    Q_LOW      = CLOCK_NUM[Q_W-1:0];
  localparam logic [Q_W-1:0]    A_INIT_REM = Q_W'(CLOCK_NUM >> ACT_W);
  localparam logic [ACT_W-1:0]  A_LOW      = CLOCK_NUM[ACT_W-1:0];

  localparam logic [ACT_W-1:0]  TC_BASE = 17'h10000;

  // Board version classes.
  localparam logic [VER_W-1:0] VER_RESET = 10'h200;
  localparam logic [VER_W-1:0] VER_NEW   = 10'h300;
  localparam logic [VER_W-1:0] VER_MID   = 10'h200;

  // Rate limits in hertz.
  localparam logic [RATE_W-1:0] RATE_FLOOR = 16'd4000;
  localparam logic [RATE_W-1:0] RATE_11025 = 16'd11025;
  localparam logic [RATE_W-1:0] RATE_13000 = 16'd13000;
  localparam logic [RATE_W-1:0] RATE_15000 = 16'd15000;
  localparam logic [RATE_W-1:0] RATE_22050 = 16'd22050;
  localparam logic [RATE_W-1:0] RATE_23000 = 16'd23000;
  localparam logic [RATE_W-1:0] RATE_44100 = 16'd44100;

endpackage

// ----- hw/rtl/sample_rate_time_constant.sv -----
// Channel   | Handshake           | Payload
// ----------+---------------------+--------------------------------------------
// request   | req_valid/req_stall | is_playback, is_stereo, requested_rate
// result    | res_valid/res_stall | time_constant, actual_rate, high_speed
// config    | cfg_valid/cfg_ready | cfg_data (board_version, 10 bits)
//
// A new request is taken in every cycle while the result side keeps up.
// Pipeline: one clamp stage, 16 cells for q, 17 cells for the achieved rate and
// the result register; the two dividers each give one quotient bit per cell.
// Reset is synchronous and active high; it empties every stage and sets the
// board version to 0x200. The configuration port is always ready. A stalled
// result holds; stages behind it keep filling, so requests go in until all fill.
module sample_rate_time_constant import srtc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              is_playback,
  input  logic              is_stereo,
  input  logic [RATE_W-1:0] requested_rate,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [TC_W-1:0]   time_constant,
  output logic [RATE_W-1:0] actual_rate,
  output logic              high_speed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VER_W-1:0]  cfg_data
);

  // Board version register; the host is to write it only while no request is in
  // flight. The block itself does not enforce this.
  logic [VER_W-1:0] board_version;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_version <= VER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      board_version <= cfg_data;
    end
  end

  // Pick the ceiling and threshold for the version class, then clamp the
  // rate. The oldest class never reports high speed.
  logic [RATE_W-1:0] ceil_rate;
  logic [RATE_W-1:0] thresh;
  logic              hs_capable;
  logic [RATE_W-1:0] rate_clamped;

  always_comb begin
    priority if (board_version >= VER_NEW) begin
      thresh     = is_stereo ? RATE_11025 : RATE_23000;
      ceil_rate  = is_stereo ? RATE_22050 : RATE_44100;
      hs_capable = 1'b1;
    end else if (board_version > VER_MID) begin
      thresh     = is_playback ? RATE_23000 : RATE_13000;
      ceil_rate  = is_playback ? RATE_44100 : RATE_15000;
      hs_capable = 1'b1;
    end else begin
      thresh     = RATE_23000;
      ceil_rate  = is_playback ? RATE_23000 : RATE_13000;
      hs_capable = 1'b0;
    end
    rate_clamped = (requested_rate > ceil_rate) ? ceil_rate : requested_rate;
    if (rate_clamped < RATE_FLOOR) begin
      rate_clamped = RATE_FLOOR;
    end
  end

  // Front stage: holds the divisor for the first division and the flags
  // that ride along.
  logic              front_valid;
  logic [DIVR_W-1:0] front_divisor;
  logic              front_stereo;
  logic              front_hs;
  logic              front_take;
  logic              q_in_ready;

  assign front_take = !front_valid || q_in_ready;
  assign req_stall  = !front_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (front_take) begin
      front_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_take) begin
      front_divisor <= is_stereo ? {rate_clamped, 1'b0} : {1'b0, rate_clamped};
      front_stereo  <= is_stereo;
      front_hs      <= hs_capable && (rate_clamped > thresh);
    end
  end

  // q = 256000000 / (rate << stereo).
  logic           q_valid;
  logic           a_in_ready;
  logic [Q_W-1:0] q_quot;
  logic [1:0]     q_side;

  srtc_divider #(
    .DW(DIVR_W), .QW(Q_W), .SW(2), .INIT_REM(Q_INIT_REM), .NUM_LOW(Q_LOW)
  ) u_q_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (q_in_ready),
    .divisor   (front_divisor),
    .side      ({front_stereo, front_hs}),
    .out_valid (q_valid),
    .out_ready (a_in_ready),
    .quot      (q_quot),
    .out_side  (q_side)
  );

  // Achieved rate before the stereo shift: 256000000 / q. q rides along
  // for the time constant.
  logic             a_valid;
  logic             res_take;
  logic [ACT_W-1:0] a_quot;
  logic [Q_W+1:0]   a_side;

  srtc_divider #(
    .DW(Q_W), .QW(ACT_W), .SW(Q_W + 2), .INIT_REM(A_INIT_REM), .NUM_LOW(A_LOW)
  ) u_a_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (a_in_ready),
    .divisor   (q_quot),
    .side      ({q_quot, q_side}),
    .out_valid (a_valid),
    .out_ready (res_take),
    .quot      (a_quot),
    .out_side  (a_side)
  );

  // Result register. q is at least 2902 here, so 65536 - q fits 16 bits
  // and its upper byte is the time constant.
  logic [Q_W-1:0]   a_q;
  logic             a_stereo;
  logic             a_hs;
  logic [ACT_W-1:0] tc_full;

  assign a_q      = a_side[Q_W+1:2];
  assign a_stereo = a_side[1];
  assign a_hs     = a_side[0];
  assign tc_full  = TC_BASE - {1'b0, a_q};
  assign res_take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      time_constant <= tc_full[15:8];
      actual_rate   <= a_stereo ? a_quot[ACT_W-1:1] : a_quot[RATE_W-1:0];
      high_speed    <= a_hs;
    end
  end

endmodule

// ----- hw/rtl/srtc_div_cell.sv -----
// One restoring division step: brings in one numerator bit, tries the
// subtraction and shifts one quotient bit in.
module srtc_div_cell import srtc_pkg::*; #(
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 2,
  parameter bit          DBIT = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_divisor,
  input  logic [QW-1:0] in_quot,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_divisor,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic [DW-1:0] rem_next;

  assign trial    = {in_rem, DBIT};
  assign diff     = trial - {1'b0, in_divisor};
  assign qbit     = (trial >= {1'b0, in_divisor});
  assign rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_rem     <= rem_next;
      out_divisor <= in_divisor;
      out_quot    <= {in_quot[QW-2:0], qbit};
      out_side    <= in_side;
    end
  end

endmodule

// ----- hw/rtl/srtc_divider.sv -----
// Constant numerator divided by a variable divisor, one quotient bit per
// cell. Each stage moves on when it is empty or the stage after it moves.
module srtc_divider import srtc_pkg::*; #(
  parameter int unsigned     DW = 17,
  parameter int unsigned     QW = 16,
  parameter int unsigned     SW = 2,
  parameter logic [DW-1:0]   INIT_REM = '0,
  parameter logic [QW-1:0]   NUM_LOW = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] out_side
);

  logic          v   [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] qt  [QW+1];
  logic [SW-1:0] sd  [QW+1];
  logic          take [QW+1];

  assign v[0]   = in_valid;
  assign rem[0] = INIT_REM;
  assign dv[0]  = divisor;
  assign qt[0]  = '0;
  assign sd[0]  = side;

  assign take[QW] = !v[QW] || out_ready;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    assign take[k] = !v[k+1] || take[k+1];

    srtc_div_cell #(
      .DW(DW), .QW(QW), .SW(SW), .DBIT(NUM_LOW[QW-1-k])
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .take        (take[k]),
      .in_valid    (v[k]),
      .in_rem      (rem[k]),
      .in_divisor  (dv[k]),
      .in_quot     (qt[k]),
      .in_side     (sd[k]),
      .out_valid   (v[k+1]),
      .out_rem     (rem[k+1]),
      .out_divisor (dv[k+1]),
      .out_quot    (qt[k+1]),
      .out_side    (sd[k+1])
    );
  end

  assign in_ready  = take[0];
  assign out_valid = v[QW];
  assign quot      = qt[QW];
  assign out_side  = sd[QW];

endmodule
